FILE: design/nrmc_pkg.sv
// shared types, status codes, character codes and small lookup functions
// for the rmc time parser; no dependencies
package nrmc_pkg;

   localparam int MAX_LINE = 128;

   localparam logic [2:0] ST_NOFIX  = 3'd0;
   localparam logic [2:0] ST_OK     = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_CSUM   = 3'd3;
   localparam logic [2:0] ST_PARSE  = 3'd4;
   localparam logic [2:0] ST_JUMP   = 3'd5;

   localparam logic [1:0] CSR_ENABLE  = 2'd0;
   localparam logic [1:0] CSR_ZONE_HR = 2'd1;
   localparam logic [1:0] CSR_SUMMER  = 2'd2;
   localparam logic [1:0] CSR_ZONE_MN = 2'd3;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_FIX    = 8'h41;

   typedef logic [3:0] bcd_type;
   typedef bcd_type [5:0] digits_type;

   typedef struct packed {
      logic [2:0] status;
      digits_type tdig;
      digits_type ddig;
   } line_rec_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] utc;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic [6:0]  day;
      logic [6:0]  month;
      logic [6:0]  year;
   } fix_rec_type;

   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0: c = 8'h24;
         3'd1: c = 8'h47;
         3'd2: c = 8'h50;
         3'd3: c = 8'h52;
         3'd4: c = 8'h4D;
         3'd5: c = 8'h43;
         3'd6: c = 8'h2C;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [8:0] days_before(input logic [3:0] mo);
      logic [8:0] d;
      unique case (mo)
         4'd1:  d = 9'd0;
         4'd2:  d = 9'd31;
         4'd3:  d = 9'd59;
         4'd4:  d = 9'd90;
         4'd5:  d = 9'd120;
         4'd6:  d = 9'd151;
         4'd7:  d = 9'd181;
         4'd8:  d = 9'd212;
         4'd9:  d = 9'd243;
         4'd10: d = 9'd273;
         4'd11: d = 9'd304;
         4'd12: d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   function automatic logic [6:0] digit_pair(input bcd_type hi, input bcd_type lo);
      return 7'({3'b0, hi} * 7'd10) + {3'b0, lo};
   endfunction

endpackage

FILE: design/nrmc_line_parser.sv
// byte input register and per-line parsing state (prefix, checksum, fields)
// depends on nrmc_pkg
module nrmc_line_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 enable,
   input  logic                 req_valid,
   input  logic [7:0]           req_rx_byte,
   output logic                 rec_valid,
   output nrmc_pkg::line_rec_type rec
);
   import nrmc_pkg::*;

   logic       byte_vld_ff;
   logic [7:0] byte_ff;

   logic       active_ff, active_in;
   logic [2:0] ppos_ff, ppos_in;
   logic       pok_ff, pok_in;
   logic [7:0] len_ff, len_in;
   logic [3:0] fnum_ff, fnum_in;
   logic [7:0] fchars_ff, fchars_in;
   logic [7:0] xor_ff, xor_in;
   logic       star_ff, star_in;
   logic [7:0] csum_ff, csum_in;
   logic [1:0] hcnt_ff, hcnt_in;
   logic       hbad_ff, hbad_in;
   digits_type tdig_ff, tdig_in;
   logic       tok_ff, tok_in;
   logic [7:0] fix_ff, fix_in;
   digits_type ddig_ff, ddig_in;
   logic       dok_ff, dok_in;
   logic       stop_ff, stop_in;

   logic         rec_vld_ff, rec_vld_in;
   line_rec_type rec_ff, rec_in;

   logic       is_digit;
   logic [3:0] hex_val;
   logic       hex_ok;

   always_comb begin
      is_digit = (byte_ff >= 8'h30) && (byte_ff <= 8'h39);
      hex_ok   = 1'b1;
      hex_val  = 4'd0;
      if (is_digit) begin
         hex_val = 4'(byte_ff - 8'h30);
      end else if ((byte_ff >= 8'h41) && (byte_ff <= 8'h46)) begin
         hex_val = 4'(byte_ff - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      active_in = active_ff; ppos_in = ppos_ff; pok_in = pok_ff; len_in = len_ff;
      fnum_in = fnum_ff; fchars_in = fchars_ff; xor_in = xor_ff; star_in = star_ff;
      csum_in = csum_ff; hcnt_in = hcnt_ff; hbad_in = hbad_ff; tdig_in = tdig_ff;
      tok_in = tok_ff; fix_in = fix_ff; ddig_in = ddig_ff; dok_in = dok_ff;
      stop_in = stop_ff;
      rec_vld_in = 1'b0;
      rec_in = '{status: ST_OK, tdig: tdig_ff, ddig: ddig_ff};

      if (byte_vld_ff && enable) begin
         priority if (byte_ff == CH_DOLLAR) begin
            active_in = 1'b1; ppos_in = 3'd1; pok_in = 1'b0; len_in = 8'd1;
            fnum_in = 4'd0; fchars_in = 8'd0; xor_in = 8'd0; star_in = 1'b0;
            csum_in = 8'd0; hcnt_in = 2'd0; hbad_in = 1'b0; tdig_in = '0;
            tok_in = 1'b0; fix_in = 8'd0; ddig_in = '0; dok_in = 1'b0;
            stop_in = 1'b0;
         end else if (byte_ff == CH_LF) begin
            active_in = 1'b0;
            if (active_ff && pok_ff) begin
               rec_vld_in = 1'b1;
               priority if ((len_ff >= 8'(MAX_LINE)) || !star_ff) begin
                  rec_in.status = ST_PARSE;
               end else if (hbad_ff || (hcnt_ff < 2'd2) || (csum_ff != xor_ff)) begin
                  rec_in.status = ST_CSUM;
               end else if (!tok_ff) begin
                  rec_in.status = ST_PARSE;
               end else if (fix_ff != CH_FIX) begin
                  rec_in.status = ST_NOFIX;
               end else if (!dok_ff) begin
                  rec_in.status = ST_PARSE;
               end else begin
                  rec_in.status = ST_OK;
               end
            end
         end else if (active_ff) begin
            if (len_ff < 8'(MAX_LINE)) begin
               len_in = len_ff + 8'd1;
            end
            priority if (!pok_ff) begin
               if ((ppos_ff < 3'd7) && (byte_ff == prefix_char(ppos_ff))) begin
                  xor_in  = xor_ff ^ byte_ff;
                  ppos_in = ppos_ff + 3'd1;
                  if (ppos_ff == 3'd6) begin
                     pok_in = 1'b1; fnum_in = 4'd1; fchars_in = 8'd0; stop_in = 1'b0;
                  end
               end else begin
                  active_in = 1'b0;
               end
            end else if (star_ff) begin
               if (hcnt_ff < 2'd2) begin
                  if (!hex_ok) begin
                     hbad_in = 1'b1;
                  end
                  csum_in = {csum_ff[3:0], hex_val};
                  hcnt_in = hcnt_ff + 2'd1;
               end
            end else if (byte_ff == CH_STAR) begin
               star_in = 1'b1;
            end else if (byte_ff == CH_COMMA) begin
               xor_in = xor_ff ^ byte_ff;
               if (fnum_ff == 4'd1) begin
                  tok_in = fchars_ff >= 8'd6;
               end
               if (fnum_ff == 4'd9) begin
                  dok_in = fchars_ff == 8'd6;
               end
               if (fnum_ff < 4'd15) begin
                  fnum_in = fnum_ff + 4'd1;
               end
               fchars_in = 8'd0;
               stop_in   = 1'b0;
            end else begin
               xor_in = xor_ff ^ byte_ff;
               if (((fnum_ff == 4'd1) || (fnum_ff == 4'd9)) && (fchars_ff < 8'd6)) begin
                  if (stop_ff || !is_digit) begin
                     stop_in = 1'b1;
                  end else if (fnum_ff == 4'd1) begin
                     tdig_in = {tdig_ff[4:0], hex_val};
                  end else begin
                     ddig_in = {ddig_ff[4:0], hex_val};
                  end
               end
               if ((fnum_ff == 4'd2) && (fchars_ff == 8'd0)) begin
                  fix_in = byte_ff;
               end
               if (fchars_ff < 8'd255) begin
                  fchars_in = fchars_ff + 8'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff <= 1'b0;
         rec_vld_ff  <= 1'b0;
         active_ff <= 1'b0; ppos_ff <= 3'd0; pok_ff <= 1'b0; len_ff <= 8'd0;
         fnum_ff <= 4'd0; fchars_ff <= 8'd0; xor_ff <= 8'd0; star_ff <= 1'b0;
         csum_ff <= 8'd0; hcnt_ff <= 2'd0; hbad_ff <= 1'b0; tdig_ff <= '0;
         tok_ff <= 1'b0; fix_ff <= 8'd0; ddig_ff <= '0; dok_ff <= 1'b0;
         stop_ff <= 1'b0;
      end else if (adv) begin
         byte_vld_ff <= req_valid;
         rec_vld_ff  <= rec_vld_in;
         active_ff <= active_in; ppos_ff <= ppos_in; pok_ff <= pok_in; len_ff <= len_in;
         fnum_ff <= fnum_in; fchars_ff <= fchars_in; xor_ff <= xor_in; star_ff <= star_in;
         csum_ff <= csum_in; hcnt_ff <= hcnt_in; hbad_ff <= hbad_in; tdig_ff <= tdig_in;
         tok_ff <= tok_in; fix_ff <= fix_in; ddig_ff <= ddig_in; dok_ff <= dok_in;
         stop_ff <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         byte_ff <= req_rx_byte;
         rec_ff  <= rec_in;
      end
   end

   assign rec_valid = rec_vld_ff;
   assign rec       = rec_ff;

   a_prefix_done: assert property (@(posedge clock) disable iff (reset)
      pok_ff |-> (ppos_ff == 3'd7))
      else $error("prefix flag set before full prefix");
   a_hex_count: assert property (@(posedge clock) disable iff (reset)
      (hcnt_ff != 2'd0) |-> star_ff)
      else $error("checksum digits counted without star");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (adv && rec_vld_ff) |=> !rec_vld_ff)
      else $error("two line results in consecutive beats");

endmodule

FILE: design/nrmc_time_calc.sv
// digit pairs, month check and conversion of the fix time to epoch seconds
// depends on nrmc_pkg
module nrmc_time_calc (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   rec_valid,
   input  nrmc_pkg::line_rec_type rec,
   output logic                   fix_valid,
   output nrmc_pkg::fix_rec_type  fix
);
   import nrmc_pkg::*;

   logic        s2_vld_ff;
   logic [2:0]  s2_status_ff, s2_status_in;
   logic [6:0]  s2_h_ff, s2_mi_ff, s2_s_ff, s2_d_ff, s2_mo_ff, s2_y_ff;
   logic [6:0]  h_in, mi_in, s_in, d_in, mo_in, y_in;
   logic [16:0] s2_days_ff, s2_days_in;
   logic [18:0] s2_hms_ff, s2_hms_in;

   logic        s3_vld_ff;
   fix_rec_type s3_ff, s3_in;
   logic        leap;

   always_comb begin
      h_in  = digit_pair(rec.tdig[5], rec.tdig[4]);
      mi_in = digit_pair(rec.tdig[3], rec.tdig[2]);
      s_in  = digit_pair(rec.tdig[1], rec.tdig[0]);
      d_in  = digit_pair(rec.ddig[5], rec.ddig[4]);
      mo_in = digit_pair(rec.ddig[3], rec.ddig[2]);
      y_in  = digit_pair(rec.ddig[1], rec.ddig[0]);
      s2_status_in = rec.status;
      if ((rec.status == ST_OK) && ((mo_in < 7'd1) || (mo_in > 7'd12))) begin
         s2_status_in = ST_PARSE;
      end
      leap = (mo_in > 7'd2) && (y_in[1:0] == 2'd0);
      s2_days_in = 17'd10957 + 17'({10'b0, y_in} * 17'd365)
                 + {12'b0, 5'((8'({1'b0, y_in}) + 8'd3) >> 2)}
                 + {8'b0, days_before(mo_in[3:0])} + {16'b0, leap}
                 + {10'b0, d_in} - 17'd1;
      s2_hms_in = 19'({12'b0, h_in} * 19'd3600) + 19'({12'b0, mi_in} * 19'd60)
                + {12'b0, s_in};
   end

   always_comb begin
      s3_in.status = s2_status_ff;
      s3_in.utc    = 32'({15'b0, s2_days_ff} * 32'd86400) + {13'b0, s2_hms_ff};
      s3_in.hour   = s2_h_ff;
      s3_in.minute = s2_mi_ff;
      s3_in.second = s2_s_ff;
      s3_in.day    = s2_d_ff;
      s3_in.month  = s2_mo_ff;
      s3_in.year   = s2_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= rec_valid;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_status_ff <= s2_status_in;
         s2_h_ff <= h_in; s2_mi_ff <= mi_in; s2_s_ff <= s_in;
         s2_d_ff <= d_in; s2_mo_ff <= mo_in; s2_y_ff <= y_in;
         s2_days_ff <= s2_days_in;
         s2_hms_ff  <= s2_hms_in;
         s3_ff      <= s3_in;
      end
   end

   assign fix_valid = s3_vld_ff;
   assign fix       = s3_ff;

endmodule

FILE: design/nrmc_fix_tracker.sv
// last fix and last update tracking, jump and update decisions, local time
// and the result register; depends on nrmc_pkg
module nrmc_fix_tracker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic signed [4:0]     zone_hours,
   input  logic                  summer_offset,
   input  logic [5:0]            zone_minutes,
   input  logic                  fix_valid,
   input  nrmc_pkg::fix_rec_type fix,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_status,
   output logic [31:0]           rsp_utc_seconds,
   output logic [31:0]           rsp_local_seconds,
   output logic [6:0]            rsp_hour,
   output logic [6:0]            rsp_minute,
   output logic [6:0]            rsp_second,
   output logic [6:0]            rsp_day,
   output logic [6:0]            rsp_month,
   output logic [6:0]            rsp_year
);
   import nrmc_pkg::*;

   logic [31:0] last_fix_ff, last_fix_in;
   logic [31:0] last_upd_ff, last_upd_in;
   logic        vld_ff;
   logic [2:0]  status_ff, status_in;
   logic [31:0] utc_ff, utc_in, local_ff, local_in;
   logic [6:0]  h_ff, mi_ff, s_ff, d_ff, mo_ff, y_ff;
   logic [6:0]  h_in, mi_in, s_in, d_in, mo_in, y_in;

   logic signed [32:0] diff, delta;
   logic [32:0]        diff_abs;
   logic signed [5:0]  zsum;
   logic signed [31:0] offs;
   logic [11:0]        zm_sec;

   always_comb begin
      diff     = $signed({1'b0, fix.utc}) - $signed({1'b0, last_fix_ff});
      diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
      delta    = $signed({1'b0, fix.utc}) - $signed({1'b0, last_upd_ff});
      zsum     = $signed({zone_hours[4], zone_hours}) + $signed({5'b0, summer_offset});
      zm_sec   = 12'({6'b0, zone_minutes} * 12'd60);
      offs     = 32'(zsum * 32'sd3600);
      if (zone_hours[4]) begin
         offs = offs - $signed({20'b0, zm_sec});
      end else begin
         offs = offs + $signed({20'b0, zm_sec});
      end

      last_fix_in = last_fix_ff;
      last_upd_in = last_upd_ff;
      status_in = fix.status;
      utc_in = 32'd0; local_in = 32'd0;
      h_in = 7'd0; mi_in = 7'd0; s_in = 7'd0; d_in = 7'd0; mo_in = 7'd0; y_in = 7'd0;
      if (fix.status == ST_NOFIX) begin
         h_in = fix.hour; mi_in = fix.minute; s_in = fix.second;
      end else if (fix.status == ST_OK) begin
         h_in = fix.hour; mi_in = fix.minute; s_in = fix.second;
         d_in = fix.day; mo_in = fix.month; y_in = fix.year;
         utc_in = fix.utc;
         if (fix_valid) begin
            last_fix_in = fix.utc;
         end
         if ((last_fix_ff != 32'd0) && (diff_abs > 33'd60)) begin
            status_in = ST_JUMP;
         end else if (((fix.second < 7'd5) && (delta > 33'sd10)) || (delta >= 33'sd60)) begin
            status_in = ST_UPDATE;
            local_in  = fix.utc + offs;
            if (fix_valid) begin
               last_upd_in = fix.utc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= 1'b0;
         last_fix_ff <= 32'd0;
         last_upd_ff <= 32'd0;
      end else if (adv) begin
         vld_ff      <= fix_valid;
         last_fix_ff <= last_fix_in;
         last_upd_ff <= last_upd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         status_ff <= status_in; utc_ff <= utc_in; local_ff <= local_in;
         h_ff <= h_in; mi_ff <= mi_in; s_ff <= s_in;
         d_ff <= d_in; mo_ff <= mo_in; y_ff <= y_in;
      end
   end

   assign rsp_valid         = vld_ff;
   assign rsp_status        = status_ff;
   assign rsp_utc_seconds   = utc_ff;
   assign rsp_local_seconds = local_ff;
   assign rsp_hour          = h_ff;
   assign rsp_minute        = mi_ff;
   assign rsp_second        = s_ff;
   assign rsp_day           = d_ff;
   assign rsp_month         = mo_ff;
   assign rsp_year          = y_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && ((status_ff == ST_CSUM) || (status_ff == ST_PARSE)))
      |-> ((utc_ff == 32'd0) && (h_ff == 7'd0) && (y_ff == 7'd0)))
      else $error("error beat carries time fields");
   a_local_only_update: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && (status_ff != ST_UPDATE)) |-> (local_ff == 32'd0))
      else $error("local time outside an update beat");
   a_update_tracks: assert property (@(posedge clock) disable iff (reset)
      ($past(adv) && vld_ff && (status_ff == ST_UPDATE)) |-> (last_upd_ff == utc_ff))
      else $error("last update time not taken from update beat");

endmodule

FILE: design/nmea_rmc_time_parser.sv
// rmc sentence time parser top level: control registers, byte parser,
// time conversion and result register; depends on nrmc_pkg and submodules
// a newline beat passes the byte, line record, s2, s3 and result registers
// throughput: one byte per cycle; req_ready drops only while a result waits
// synchronous active-high reset clears line state, fix history, control registers and valid flags
module nmea_rmc_time_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_utc_seconds,
   output logic [31:0] rsp_local_seconds,
   output logic [6:0]  rsp_hour,
   output logic [6:0]  rsp_minute,
   output logic [6:0]  rsp_second,
   output logic [6:0]  rsp_day,
   output logic [6:0]  rsp_month,
   output logic [6:0]  rsp_year,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata
);
   import nrmc_pkg::*;

   logic              enable_ff;
   logic signed [4:0] zone_hours_ff;
   logic              summer_ff;
   logic [5:0]        zone_min_ff;
   logic              adv;
   logic              rec_valid, fix_valid;
   line_rec_type      rec;
   fix_rec_type       fix;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         zone_hours_ff <= 5'sd0;
         summer_ff     <= 1'b0;
         zone_min_ff   <= 6'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:  enable_ff     <= csr_wdata[0];
            CSR_ZONE_HR: zone_hours_ff <= $signed(csr_wdata[4:0]);
            CSR_SUMMER:  summer_ff     <= csr_wdata[0];
            CSR_ZONE_MN: zone_min_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   nrmc_line_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .enable      (enable_ff),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .rec_valid   (rec_valid),
      .rec         (rec)
   );

   nrmc_time_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .rec_valid (rec_valid),
      .rec       (rec),
      .fix_valid (fix_valid),
      .fix       (fix)
   );

   nrmc_fix_tracker u_tracker (
      .clock             (clock),
      .reset             (reset),
      .adv               (adv),
      .zone_hours        (zone_hours_ff),
      .summer_offset     (summer_ff),
      .zone_minutes      (zone_min_ff),
      .fix_valid         (fix_valid),
      .fix               (fix),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_utc_seconds   (rsp_utc_seconds),
      .rsp_local_seconds (rsp_local_seconds),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_day           (rsp_day),
      .rsp_month         (rsp_month),
      .rsp_year          (rsp_year)
   );

endmodule

FILE: dv/tb_top.sv
// testbench for nmea_rmc_time_parser: sentence-level stimulus, a built-in
// prediction of every line result and field-by-field checking of each beat
// depends on nrmc_pkg and the design sources
`timescale 1ns / 100ps

module tb_top;
   import nrmc_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] utc_seconds;
      logic [31:0] local_seconds;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic [6:0]  day;
      logic [6:0]  month;
      logic [6:0]  year;
   } line_result_type;

   typedef enum {SUM_GOOD, SUM_WRONG, SUM_NONE, SUM_BADHEX, RAW, PAD_LONG, TRAILING} line_form_type;

   typedef struct {
      string         body;
      line_form_type form;
      bit            typed;
      logic [2:0]    status;
   } line_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_utc_seconds, rsp_local_seconds;
   logic [6:0]  rsp_hour, rsp_minute, rsp_second, rsp_day, rsp_month, rsp_year;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_ENABLE;
   logic [5:0]  csr_wdata = 6'd0;

   nmea_rmc_time_parser DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // expected line results, oldest first
   line_result_type pending_lines[$];
   int errors = 0, beats_sent = 0, lines_seen = 0, lines_predicted = 0, cycles = 0;
   int send_idle_pct = 0, recv_stall_pct = 0, hold_left = 0, calm_left = 0;
   bit line_burst = 0;
   logic [2:0] last_status;

   // parser copy
   bit          cfg_en, cfg_summer;
   int          cfg_zone_hr;
   logic [5:0]  cfg_zone_mn;
   bit          in_line, hdr_ok, star_seen, hex_bad, time_ok, date_ok, digit_stop;
   int          hdr_pos, line_len, field_no, field_len, hex_count;
   logic [7:0]  run_xor, sent_sum, fix_char;
   int unsigned time_acc, date_acc;
   logic [31:0] last_fix, last_update;

   const string rmc_hdr = "$GPRMC,";
   const int unsigned days_before_month[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243,
                                                273, 304, 334};

   function automatic int unsigned push_digit(int unsigned acc, logic [7:0] b);
      if (digit_stop || b < "0" || b > "9") begin
         digit_stop = 1;
         return acc;
      end
      return acc * 10 + (b - "0");
   endfunction

   task automatic predict_rx(input logic [7:0] b);
      line_result_type r;
      logic [31:0] h, mi, s, d, mo, y, days, utc;
      longint diff, delta, offs, u64;
      logic [3:0] v;
      r = '0;
      if (!cfg_en) return;
      beats_sent++;
      if (b == CH_DOLLAR) begin
         in_line = 1; hdr_pos = 1; hdr_ok = 0; line_len = 1; field_no = 0; field_len = 0;
         run_xor = 0; star_seen = 0; sent_sum = 0; hex_count = 0; hex_bad = 0;
         time_acc = 0; time_ok = 0; fix_char = 0; date_acc = 0; date_ok = 0;
         digit_stop = 0;
         return;
      end
      if (b == CH_LF) begin
         if (in_line && hdr_ok) begin
            h = time_acc / 10000; mi = (time_acc / 100) % 100; s = time_acc % 100;
            if (line_len >= MAX_LINE || !star_seen) r.status = ST_PARSE;
            else if (hex_bad || hex_count < 2 || sent_sum != run_xor) r.status = ST_CSUM;
            else if (!time_ok) r.status = ST_PARSE;
            else if (fix_char != CH_FIX) begin
               r.status = ST_NOFIX;
               r.hour = h; r.minute = mi; r.second = s;
            end else begin
               d = date_acc / 10000; mo = (date_acc / 100) % 100; y = date_acc % 100;
               if (!date_ok || mo < 1 || mo > 12) r.status = ST_PARSE;
               else begin
                  days = 10957 + 365 * y + (y + 3) / 4 + days_before_month[mo - 1];
                  if (mo > 2 && y % 4 == 0) days = days + 1;
                  utc = days * 86400 + (d - 32'd1) * 86400 + h * 3600 + mi * 60 + s;
                  u64 = utc;
                  diff = u64 - longint'(last_fix);
                  if (diff < 0) diff = -diff;
                  r.status = ST_OK;
                  if (last_fix != 0 && diff > 60) r.status = ST_JUMP;
                  else begin
                     delta = u64 - longint'(last_update);
                     if ((s < 5 && delta > 10) || delta >= 60) begin
                        r.status = ST_UPDATE;
                        last_update = utc;
                        offs = longint'(cfg_zone_hr + int'(cfg_summer)) * 3600;
                        if (cfg_zone_hr < 0) offs -= longint'(cfg_zone_mn) * 60;
                        else offs += longint'(cfg_zone_mn) * 60;
                        r.local_seconds = 32'(u64 + offs);
                     end
                  end
                  last_fix = utc;
                  r.utc_seconds = utc;
                  r.hour = h; r.minute = mi; r.second = s;
                  r.day = d; r.month = mo; r.year = y;
               end
            end
            pending_lines.push_back(r);
            last_status = r.status;
            lines_predicted++;
         end
         in_line = 0;
         return;
      end
      if (!in_line) return;
      if (line_len < MAX_LINE) line_len++;
      if (!hdr_ok) begin
         if (hdr_pos < 7 && b == rmc_hdr[hdr_pos]) begin
            run_xor ^= b;
            hdr_pos++;
            if (hdr_pos == 7) begin
               hdr_ok = 1; field_no = 1; field_len = 0; digit_stop = 0;
            end
         end else in_line = 0;
         return;
      end
      if (star_seen) begin
         if (hex_count < 2) begin
            v = 0;
            if (b >= "0" && b <= "9") v = b - "0";
            else if (b >= "A" && b <= "F") v = b - "A" + 10;
            else hex_bad = 1;
            sent_sum = {sent_sum[3:0], v};
            hex_count++;
         end
         return;
      end
      if (b == CH_STAR) begin
         star_seen = 1;
         return;
      end
      run_xor ^= b;
      if (b == CH_COMMA) begin
         if (field_no == 1) time_ok = field_len >= 6;
         if (field_no == 9) date_ok = field_len == 6;
         if (field_no < 15) field_no++;
         field_len = 0;
         digit_stop = 0;
         return;
      end
      if (field_no == 1 && field_len < 6) time_acc = push_digit(time_acc, b);
      if (field_no == 2 && field_len == 0) fix_char = b;
      if (field_no == 9 && field_len < 6) date_acc = push_digit(date_acc, b);
      if (field_len < 255) field_len++;
   endtask

   task automatic send_beat(input logic [7:0] b);
      @(negedge clock);
      while (!line_burst && hold_left == 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      predict_rx(b);
   endtask

   task automatic send_text(input string s);
      line_burst = ($urandom_range(7) == 0);
      for (int i = 0; i < s.len(); i++) send_beat(s[i]);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic string make_sentence(input string body, input line_form_type form);
      logic [7:0] x;
      string s;
      x = 0;
      s = body;
      if (form == RAW) return s;
      if (form == PAD_LONG) while (s.len() < 130) s = {s, ","};
      for (int i = 0; i < s.len(); i++) x ^= s[i];
      case (form)
         SUM_WRONG:  s = {"$", s, $sformatf("*%02X\n", x ^ 8'h01)};
         SUM_NONE:   s = {"$", s, "\n"};
         SUM_BADHEX: s = {"$", s, $sformatf("*%01Xg\n", x[7:4])};
         TRAILING:   s = {"$", s, $sformatf("*%02XZZ,9\n", x)};
         default:    s = {"$", s, $sformatf("*%02X\n", x)};
      endcase
      return s;
   endfunction

   task automatic write_csr(input logic [1:0] idx, input logic [5:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_ENABLE:  cfg_en = val[0];
         CSR_ZONE_HR: cfg_zone_hr = $signed(val[4:0]);
         CSR_SUMMER:  cfg_summer = val[0];
         default:     cfg_zone_mn = val;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_zone(input int zh, input bit so, input logic [5:0] zm);
      write_csr(CSR_ZONE_HR, 6'(zh & 31));
      write_csr(CSR_SUMMER, so);
      write_csr(CSR_ZONE_MN, zm);
   endtask

   task automatic drain_results();
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // receiver side: random stalls, calm stretches and a long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (calm_left > 0) begin
         calm_left <= calm_left - 1;
         rsp_ready <= 1'b1;
      end else begin
         if ($urandom_range(199) == 0) calm_left <= $urandom_range(20, 80);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] got);
      if (exp !== got) begin
         $error("%s: expected %0d, got %0d", name, exp, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      line_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         lines_seen++;
         if (pending_lines.size() == 0) begin
            $error("result beat with nothing expected, status %0d", rsp_status);
            errors++;
         end else begin
            e = pending_lines.pop_front();
            check_field("status", e.status, rsp_status);
            check_field("utc_seconds", e.utc_seconds, rsp_utc_seconds);
            check_field("local_seconds", e.local_seconds, rsp_local_seconds);
            check_field("hour", e.hour, rsp_hour);
            check_field("minute", e.minute, rsp_minute);
            check_field("second", e.second, rsp_second);
            check_field("day", e.day, rsp_day);
            check_field("month", e.month, rsp_month);
            check_field("year", e.year, rsp_year);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1500000) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // random sentences around a running time of day
   int tod, day_d, mon_d, yr_d;

   task automatic random_line();
      int pick, kind;
      string tstr, dstr, fix, s;
      logic [7:0] junk;
      pick = $urandom_range(99);
      if (pick < 8) begin
         s = "";
         repeat ($urandom_range(1, 20)) begin
            junk = $urandom_range(255);
            s = {s, string'(junk)};
         end
         send_text({s, "\n"});
         return;
      end
      if (pick < 14) begin
         send_text(make_sentence($sformatf("GPGGA,%06d,,,", $urandom_range(999999)), SUM_GOOD));
         return;
      end
      kind = $urandom_range(9);
      if (kind < 8) tod += $urandom_range(0, 3);
      else tod += $urandom_range(40, 9000);
      if (tod >= 86400) begin
         tod -= 86400;
         day_d = day_d % 28 + 1;
      end
      tstr = $sformatf("%02d%02d%02d", tod / 3600, (tod / 60) % 60, tod % 60);
      if ($urandom_range(3) == 0) tstr = {tstr, ".00"};
      dstr = $sformatf("%02d%02d%02d", day_d, mon_d, yr_d);
      fix = ($urandom_range(19) == 0) ? "V" : "A";
      if (pick >= 90) begin
         case ($urandom_range(6))
            0: tstr = tstr.substr(0, 4);
            1: tstr = {tstr.substr(0, 1), "x", tstr.substr(3, 5)};
            2: dstr = $sformatf("%02d%02d%02d", $urandom_range(99), $urandom_range(99),
                                $urandom_range(99));
            3: dstr = {dstr, "1"};
            4: dstr = "";
            5: tstr = $sformatf("%06d", $urandom_range(999999));
            default: fix = "";
         endcase
      end
      s = $sformatf("GPRMC,%s,%s,%04d.%03d,N,%05d.%03d,W,%0d.%0d,%0d.%0d,%s,,,A", tstr, fix,
                    $urandom_range(9999), $urandom_range(999), $urandom_range(99999),
                    $urandom_range(999), $urandom_range(99), $urandom_range(9),
                    $urandom_range(359), $urandom_range(9), dstr);
      if (pick >= 84 && pick < 90) begin
         case ($urandom_range(3))
            0: send_text(make_sentence(s, SUM_WRONG));
            1: send_text(make_sentence(s, SUM_NONE));
            2: send_text(make_sentence(s, SUM_BADHEX));
            default: send_text(make_sentence(s, PAD_LONG));
         endcase
      end else send_text(make_sentence(s, ($urandom_range(9) == 0) ? TRAILING : SUM_GOOD));
   endtask

   line_row_type lines_table[] = '{
      '{"GPRMC,000000,A,,,,,,,010100,,", SUM_GOOD, 1, ST_UPDATE},
      '{"GPRMC,000001,A,,,,,,,010100,,", SUM_GOOD, 1, ST_OK},
      '{"GPRMC,235959,A,4807.038,N,01131.000,E,022.4,084.4,311299,003.1,W", SUM_GOOD,
        1, ST_JUMP},
      '{"GPRMC,235959,A,,,,,,,311299,,", SUM_WRONG, 1, ST_CSUM},
      '{"GPRMC,235959,A,,,,,,,311299,,", SUM_NONE, 1, ST_PARSE},
      '{"GPRMC,235959,A,,,,,,,311299,,", SUM_BADHEX, 1, ST_CSUM},
      '{"GPRMC,123456,V,,,,,,,,,", SUM_GOOD, 1, ST_NOFIX},
      '{"GPRMC,123456,A,,,,,,,011399,,", SUM_GOOD, 1, ST_PARSE},
      '{"GPRMC,123456,A,,,,,,,010099,,", SUM_GOOD, 1, ST_PARSE},
      '{"GPRMC,12345,A,,,,,,,010100,,", SUM_GOOD, 1, ST_PARSE},
      '{"GPRMC,123456,A,,,,,,,0101001,,", SUM_GOOD, 1, ST_PARSE},
      '{"GPRMC,12a456,A,,,,,,,000100,,", SUM_GOOD, 0, ST_OK},
      '{"GPRMC,999999.99,A,,,,,,,991299,,", SUM_GOOD, 0, ST_OK},
      '{"GPRMC,999999,A,,,,,,,991299,,", TRAILING, 0, ST_OK},
      '{"GPGGA,123456,,,", SUM_GOOD, 0, ST_OK},
      '{"GPRMC,123456,A,,,,,,,010100", PAD_LONG, 1, ST_PARSE},
      '{"\n\n$GPR\n$$GPRMC,\n", RAW, 0, ST_OK}
   };

   initial begin
      int before_count;
      cfg_en = 0; cfg_summer = 0; cfg_zone_hr = 0; cfg_zone_mn = 0;
      in_line = 0; hdr_ok = 0; last_fix = 0; last_update = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed lines
      write_csr(CSR_ENABLE, 6'd1);
      set_zone(0, 0, 6'd0);
      foreach (lines_table[i]) begin
         before_count = lines_predicted;
         send_text(make_sentence(lines_table[i].body, lines_table[i].form));
         if (lines_table[i].typed && (lines_predicted == before_count
                                      || last_status != lines_table[i].status)) begin
            $error("line %0d: status expected %0d, predicted %0d", i,
                   lines_table[i].status, last_status);
            errors++;
         end
      end
      drain_results();

      // enable low: everything dropped
      write_csr(CSR_ENABLE, 6'd0);
      send_text(make_sentence("GPRMC,000000,A,,,,,,,010100,,", SUM_GOOD));
      write_csr(CSR_ENABLE, 6'd1);

      for (int ph = 0; ph < 4; ph++) begin
         drain_results();
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  set_zone(-12, 1, 6'd59); end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  set_zone(14, 0, 6'd63); end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; set_zone(-1, 1, 6'd30); end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; set_zone(5, 0, 6'd0); end
         endcase
         tod = $urandom_range(86399);
         day_d = $urandom_range(1, 28); mon_d = $urandom_range(1, 12);
         yr_d = (ph == 0) ? 99 : $urandom_range(99);
         if (ph == 2) hold_left = 400;
         before_count = beats_sent;
         while (beats_sent - before_count < 230) random_line();
      end

      drain_results();
      $display("covered %0d accepted bytes and %0d checked line results over four zone",
               beats_sent, lines_seen);
      $display("settings, idle and stall mixes, with %0d mismatches", errors);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: filelist.f
design/nrmc_pkg.sv
design/nrmc_line_parser.sv
design/nrmc_time_calc.sv
design/nrmc_fix_tracker.sv
design/nmea_rmc_time_parser.sv
dv/tb_top.sv
